>>> rtl/assert_macros.svh
// assertion macros shared by the rotation unit rtl
// relies on clk_i and rst_ni being visible where a macro is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on every rising clock edge out of reset
`define ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/rpabc_pkg.sv
// shared constants, codes and types of the box-centre rotation unit
// no dependencies
package rpabc_pkg;

  localparam int FIELD_W    = 32;
  localparam int TRIG_W     = 16;
  localparam int OP_W       = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam int COORD_WIDTH_DEF    = 32;
  localparam int TRIG_FRAC_BITS_DEF = 14;

  // item operation codes
  localparam logic [OP_W-1:0] OP_CLEAR     = 2'd0;
  localparam logic [OP_W-1:0] OP_MEASURE   = 2'd1;
  localparam logic [OP_W-1:0] OP_TRANSFORM = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_AXIS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SIN  = 2'd2;

  localparam logic AXIS_X = 1'b0;
  localparam logic AXIS_Y = 1'b1;

  // box seed magnitude, 100 in q16.16
  localparam longint SEED_Q16 = 64'sd6553600;

  localparam logic signed [TRIG_W-1:0] COS_RESET = 16'sd16384;
  localparam logic signed [TRIG_W-1:0] SIN_RESET = 16'sd0;

  typedef struct packed {
    logic clr;
    logic meas;
  } box_ctl_t;

  typedef struct packed {
    logic ld_prod;
    logic ld_res;
  } lane_en_t;

  // clamp a constant into the signed range of a cw-bit coordinate
  function automatic longint clamp_seed(int cw, longint v);
    longint hi;
    longint lo;
    longint r;
    hi = (longint'(1) <<< (cw - 1)) - 1;
    lo = -hi - 1;
    r  = v;
    if (v > hi) r = hi;
    if (v < lo) r = lo;
    return r;
  endfunction

endpackage

>>> rtl/rpabc_if.sv
// point and result channel interfaces with valid/ready handshake
// depends on rpabc_pkg
interface rpabc_in_if;
  import rpabc_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [OP_W-1:0]           op;
  logic signed [FIELD_W-1:0] x_coord;
  logic signed [FIELD_W-1:0] y_coord;
  logic signed [FIELD_W-1:0] z_coord;

  modport source (output valid, op, x_coord, y_coord, z_coord, input ready);
  modport sink   (input valid, op, x_coord, y_coord, z_coord, output ready);
endinterface

interface rpabc_out_if;
  import rpabc_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [FIELD_W-1:0] x_out;
  logic signed [FIELD_W-1:0] y_out;
  logic signed [FIELD_W-1:0] z_out;
  logic                      saturated;

  modport source (output valid, x_out, y_out, z_out, saturated, input ready);
  modport sink   (input valid, x_out, y_out, z_out, saturated, output ready);
endinterface

>>> rtl/rpabc_box.sv
// bounding box tracker: min/max registers per axis and floor centre
// depends on rpabc_pkg
module rpabc_box #(
  parameter int COORD_WIDTH = rpabc_pkg::COORD_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  rpabc_pkg::box_ctl_t           ctl_i,
  input  logic signed [COORD_WIDTH-1:0] pt_i  [3],
  output logic signed [COORD_WIDTH-1:0] ctr_o [3]
);
  import rpabc_pkg::*;

  localparam logic signed [COORD_WIDTH-1:0] MaxSeed =
    COORD_WIDTH'(clamp_seed(COORD_WIDTH, -SEED_Q16));
  localparam logic signed [COORD_WIDTH-1:0] MinSeed =
    COORD_WIDTH'(clamp_seed(COORD_WIDTH, SEED_Q16));

  logic signed [COORD_WIDTH-1:0] max_q [3];
  logic signed [COORD_WIDTH-1:0] min_q [3];
  logic signed [COORD_WIDTH:0]   sum   [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < 3; a++) begin
        max_q[a] <= MaxSeed;
        min_q[a] <= MinSeed;
      end
    end else if (ctl_i.clr) begin
      for (int a = 0; a < 3; a++) begin
        max_q[a] <= MaxSeed;
        min_q[a] <= MinSeed;
      end
    end else if (ctl_i.meas) begin
      for (int a = 0; a < 3; a++) begin
        if (max_q[a] < pt_i[a]) max_q[a] <= pt_i[a];
        if (min_q[a] > pt_i[a]) min_q[a] <= pt_i[a];
      end
    end
  end

  // floor of the mean is the sum with its lsb dropped
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      sum[a]   = (COORD_WIDTH+1)'(min_q[a]) + (COORD_WIDTH+1)'(max_q[a]);
      ctr_o[a] = sum[a][COORD_WIDTH:1];
    end
  end

endmodule

>>> rtl/rpabc_lane.sv
// one rotated coordinate: two products, exact sum, floor shift, recentre, clamp
// depends on rpabc_pkg
module rpabc_lane #(
  parameter int COORD_WIDTH    = rpabc_pkg::COORD_WIDTH_DEF,
  parameter int TRIG_FRAC_BITS = rpabc_pkg::TRIG_FRAC_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  rpabc_pkg::lane_en_t            en_i,
  input  logic signed [COORD_WIDTH-1:0]  ctr_i,
  input  logic signed [COORD_WIDTH:0]    da_i,
  input  logic signed [COORD_WIDTH:0]    db_i,
  input  logic signed [rpabc_pkg::TRIG_W:0] ta_i,
  input  logic signed [rpabc_pkg::TRIG_W:0] tb_i,
  output logic signed [COORD_WIDTH-1:0]  res_o,
  output logic                           sat_o
);
  import rpabc_pkg::*;

  localparam int DW = COORD_WIDTH + 1;
  localparam int TW = TRIG_W + 1;
  localparam int PW = DW + TW;
  localparam int SW = PW + 1;
  localparam int QW = SW - TRIG_FRAC_BITS;
  localparam int RW = ((QW > COORD_WIDTH) ? QW : COORD_WIDTH) + 1;

  localparam logic signed [COORD_WIDTH-1:0] CMax = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam logic signed [COORD_WIDTH-1:0] CMin = {1'b1, {(COORD_WIDTH-1){1'b0}}};

  logic signed [PW-1:0]          pa_d, pb_d, pa_q, pb_q;
  logic signed [COORD_WIDTH-1:0] ctr_q;
  logic signed [SW-1:0]          sum;
  logic signed [QW-1:0]          quo;
  logic signed [RW-1:0]          rot;
  logic signed [COORD_WIDTH-1:0] res_d, res_q;
  logic                          sat_d, sat_q;

  assign pa_d = ta_i * da_i;
  assign pb_d = tb_i * db_i;

  always_ff @(posedge clk_i) begin
    if (en_i.ld_prod) begin
      pa_q  <= pa_d;
      pb_q  <= pb_d;
      ctr_q <= ctr_i;
    end
  end

  // arithmetic shift of the exact sum is the floor division
  always_comb begin
    sum = SW'(pa_q) + SW'(pb_q);
    quo = sum[SW-1:TRIG_FRAC_BITS];
    rot = RW'(ctr_q) + RW'(quo);
    res_d = rot[COORD_WIDTH-1:0];
    sat_d = 1'b0;
    if (rot > RW'(CMax)) begin
      res_d = CMax;
      sat_d = 1'b1;
    end else if (rot < RW'(CMin)) begin
      res_d = CMin;
      sat_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sat_q <= 1'b0;
    end else if (en_i.ld_res) begin
      sat_q <= sat_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.ld_res) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;
  assign sat_o = sat_q;

endmodule

>>> rtl/rotate_points_about_box_center_unit.sv
// rotation of points about their bounding box centre, x or y axis, q16.16 in q2.14 trig
// a transform result passes stages 1, 2, 3 and the output register; a stall holds it in place
// one transaction per cycle if no stall; four register stages, ready ripples back through them
// clear and measure transactions finish in stage 1 and give no result
// reset (async, active low): empty pipe, box at its seeds, axis x, cos 1.0, sin 0
module rotate_points_about_box_center_unit #(
  parameter int COORD_WIDTH    = rpabc_pkg::COORD_WIDTH_DEF,
  parameter int TRIG_FRAC_BITS = rpabc_pkg::TRIG_FRAC_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  rpabc_in_if.sink                             pts_i,
  rpabc_out_if.source                          res_o,
  input  logic                                 cfg_we_i,
  input  logic [rpabc_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [rpabc_pkg::CFG_DATA_W-1:0]     cfg_data_i
);
  import rpabc_pkg::*;
  `include "assert_macros.svh"

  localparam int CW     = COORD_WIDTH;
  localparam int InBits = (CW < FIELD_W) ? CW : FIELD_W;

  // configuration registers
  logic                     axis_q;
  logic signed [TRIG_W-1:0] cos_q, sin_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      axis_q <= AXIS_X;
      cos_q  <= COS_RESET;
      sin_q  <= SIN_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_AXIS: axis_q <= cfg_data_i[0];
        CFG_COS:  cos_q  <= $signed(cfg_data_i);
        CFG_SIN:  sin_q  <= $signed(cfg_data_i);
        default:  ; // unmapped index, write dropped
      endcase
    end
  end

  // stage valids and the ready chain; each stage loads when its successor can
  logic v1_q, v2_q, v3_q, vo_q;
  logic ld_1, ld_2, ld_3, ld_o;

  assign ld_o = !vo_q || res_o.ready;
  assign ld_3 = !v3_q || ld_o;
  assign ld_2 = !v2_q || ld_3;
  assign ld_1 = !v1_q || ld_2;
  assign pts_i.ready = ld_1;

  // stage 1: accepted transaction, coordinates sign extended to the working width
  logic [OP_W-1:0]      op1_q;
  logic signed [CW-1:0] pt1_q [3];
  logic                 acc;

  assign acc = pts_i.valid && ld_1;

  always_ff @(posedge clk_i) begin
    if (acc) begin
      op1_q    <= pts_i.op;
      pt1_q[0] <= CW'($signed(pts_i.x_coord[InBits-1:0]));
      pt1_q[1] <= CW'($signed(pts_i.y_coord[InBits-1:0]));
      pt1_q[2] <= CW'($signed(pts_i.z_coord[InBits-1:0]));
    end
  end

  // box update happens as the transaction leaves stage 1, so a following
  // transform in stage 1 already sees the widened box
  box_ctl_t             box_ctl;
  logic                 go1, tr1;
  logic signed [CW-1:0] ctr [3];

  assign go1          = v1_q && ld_2;
  assign tr1          = v1_q && (op1_q == OP_TRANSFORM);
  assign box_ctl.clr  = go1 && (op1_q == OP_CLEAR);
  assign box_ctl.meas = go1 && (op1_q == OP_MEASURE);

  rpabc_box #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_box (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (box_ctl),
    .pt_i   (pt1_q),
    .ctr_o  (ctr)
  );

  // offsets from the centre; lane p is y for the x axis and x for the y axis,
  // lane z is always z, and the remaining coordinate passes straight through
  logic signed [CW:0]   dx, dy, dz;
  logic signed [CW-1:0] ctr_p2_q, ctr_z2_q, pass2_q;
  logic signed [CW:0]   dp2_q, dz2_q;

  assign dx = (CW+1)'(pt1_q[0]) - (CW+1)'(ctr[0]);
  assign dy = (CW+1)'(pt1_q[1]) - (CW+1)'(ctr[1]);
  assign dz = (CW+1)'(pt1_q[2]) - (CW+1)'(ctr[2]);

  always_ff @(posedge clk_i) begin
    if (tr1 && ld_2) begin
      ctr_p2_q <= (axis_q == AXIS_Y) ? ctr[0] : ctr[1];
      ctr_z2_q <= ctr[2];
      dp2_q    <= (axis_q == AXIS_Y) ? dx : dy;
      dz2_q    <= dz;
      pass2_q  <= (axis_q == AXIS_Y) ? pt1_q[1] : pt1_q[0];
    end
  end

  // trig operands, one bit wider so that minus sin never wraps
  logic signed [TRIG_W:0] cos_w, sin_w, nsin_w;
  logic signed [TRIG_W:0] ta_p, tb_p, ta_z, tb_z;

  assign cos_w  = (TRIG_W+1)'(cos_q);
  assign sin_w  = (TRIG_W+1)'(sin_q);
  assign nsin_w = -sin_w;
  // about x: y' = c*dy - s*dz, z' = s*dy + c*dz
  // about y: x' = c*dx + s*dz, z' = c*dz - s*dx
  assign ta_p = cos_w;
  assign tb_p = (axis_q == AXIS_Y) ? sin_w : nsin_w;
  assign ta_z = (axis_q == AXIS_Y) ? nsin_w : sin_w;
  assign tb_z = cos_w;

  // stage 3 (products inside the lanes) and the output register
  lane_en_t             lane_en;
  logic signed [CW-1:0] pass3_q, passo_q;
  logic signed [CW-1:0] res_p, res_z;
  logic                 sat_p, sat_z;

  assign lane_en.ld_prod = v2_q && ld_3;
  assign lane_en.ld_res  = v3_q && ld_o;

  rpabc_lane #(
    .COORD_WIDTH    (COORD_WIDTH),
    .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
  ) u_lane_p (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (lane_en),
    .ctr_i  (ctr_p2_q),
    .da_i   (dp2_q),
    .db_i   (dz2_q),
    .ta_i   (ta_p),
    .tb_i   (tb_p),
    .res_o  (res_p),
    .sat_o  (sat_p)
  );

  rpabc_lane #(
    .COORD_WIDTH    (COORD_WIDTH),
    .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
  ) u_lane_z (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (lane_en),
    .ctr_i  (ctr_z2_q),
    .da_i   (dp2_q),
    .db_i   (dz2_q),
    .ta_i   (ta_z),
    .tb_i   (tb_z),
    .res_o  (res_z),
    .sat_o  (sat_z)
  );

  always_ff @(posedge clk_i) begin
    if (lane_en.ld_prod) pass3_q <= pass2_q;
    if (lane_en.ld_res)  passo_q <= pass3_q;
  end

  // only transforms go beyond stage 1
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (ld_1) v1_q <= pts_i.valid;
      if (ld_2) v2_q <= tr1;
      if (ld_3) v3_q <= v2_q;
      if (ld_o) vo_q <= v3_q;
    end
  end

  // passthrough coordinate is already in range and never saturates
  assign res_o.valid     = vo_q;
  assign res_o.x_out     = FIELD_W'((axis_q == AXIS_Y) ? res_p : passo_q);
  assign res_o.y_out     = FIELD_W'((axis_q == AXIS_Y) ? passo_q : res_p);
  assign res_o.z_out     = FIELD_W'(res_z);
  assign res_o.saturated = sat_p || sat_z;

  `ASSERT_NEXT(a_s3_held_on_stall, v3_q && !ld_o, v3_q, "stage 3 transaction lost under stall")
  `ASSERT_NEXT(a_no_result_for_box_ops, go1 && !tr1, !v2_q, "box transaction moved past stage 1")
  `ASSERT_IMPL(a_out_from_s3, $rose(vo_q), $past(v3_q), "result appeared without a stage 3 source")

endmodule

>>> test/rotate_points_about_box_center_unit_test.sv
// testbench for the box-centre rotation unit: directed corner points, then random point clouds
// measured and transformed under several rotation settings, checked against a built-in predictor
// depends on rpabc_pkg, rpabc_in_if, rpabc_out_if and rotate_points_about_box_center_unit
module rotate_points_about_box_center_unit_test;
  import rpabc_pkg::*;

  // cycles from acceptance until a transform result can be taken at the output
  localparam int PIPE_LATENCY = 4;
  localparam int FRAC         = TRIG_FRAC_BITS_DEF;

  // codes the package leaves unnamed
  localparam logic [OP_W-1:0]      OP_UNUSED  = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  localparam logic signed [FIELD_W-1:0] COORD_MAX = {1'b0, {(FIELD_W-1){1'b1}}};
  localparam logic signed [FIELD_W-1:0] COORD_MIN = {1'b1, {(FIELD_W-1){1'b0}}};
  localparam longint COORD_HI = 64'sd2147483647;
  localparam longint COORD_LO = -COORD_HI - 1;
  // 200.0 in q16.16, spread of the clustered random points
  localparam int SPREAD = 13107200;
  localparam int ONE_Q16 = 65536;

  typedef struct packed {
    logic signed [FIELD_W-1:0] x;
    logic signed [FIELD_W-1:0] y;
    logic signed [FIELD_W-1:0] z;
    logic                      sat;
  } rotated_point_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  rpabc_in_if  pts_if ();
  rpabc_out_if res_if ();

  rotate_points_about_box_center_unit i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pts_i      (pts_if),
    .res_o      (res_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // predictor state: rotation settings and the bounding box per axis (x, y, z)
  logic                     axis_q;
  logic signed [TRIG_W-1:0] cos_q;
  logic signed [TRIG_W-1:0] sin_q;
  longint                   box_hi [3];
  longint                   box_lo [3];

  rotated_point_t pending_points [$];

  int fail_count      = 0;
  int items_sent      = 0;
  int hold_off_cycles = 0;
  bit tx_idle_on      = 1'b1;
  bit rx_idle_on      = 1'b1;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  function automatic void reseed_box();
    int i;
    for (i = 0; i < 3; i++) begin
      box_hi[i] = -SEED_Q16;
      box_lo[i] = SEED_Q16;
    end
  endfunction

  function automatic logic signed [FIELD_W-1:0] clamp_coord(input longint v, inout logic sat);
    if (v > COORD_HI) begin
      sat = 1'b1;
      return COORD_MAX;
    end
    if (v < COORD_LO) begin
      sat = 1'b1;
      return COORD_MIN;
    end
    return FIELD_W'(v);
  endfunction

  // follows one accepted point transaction: box update or rotated point
  function automatic void track_point(input logic [OP_W-1:0] op,
                                      input logic signed [FIELD_W-1:0] x,
                                      input logic signed [FIELD_W-1:0] y,
                                      input logic signed [FIELD_W-1:0] z);
    longint p [3];
    longint c [3];
    longint d [3];
    longint r [3];
    longint cs;
    longint sn;
    int i;
    logic sat;
    rotated_point_t res;
    p[0] = x;
    p[1] = y;
    p[2] = z;
    case (op)
      OP_CLEAR: begin
        reseed_box();
      end
      OP_MEASURE: begin
        for (i = 0; i < 3; i++) begin
          if (p[i] > box_hi[i]) box_hi[i] = p[i];
          if (p[i] < box_lo[i]) box_lo[i] = p[i];
        end
      end
      OP_TRANSFORM: begin
        cs = cos_q;
        sn = sin_q;
        // centre rounds towards minus infinity, as does the product shift
        for (i = 0; i < 3; i++) begin
          c[i] = (box_lo[i] + box_hi[i]) >>> 1;
          d[i] = p[i] - c[i];
        end
        if (axis_q == AXIS_X) begin
          r[0] = p[0];
          r[1] = c[1] + ((cs * d[1] - sn * d[2]) >>> FRAC);
          r[2] = c[2] + ((sn * d[1] + cs * d[2]) >>> FRAC);
        end else begin
          r[0] = c[0] + ((cs * d[0] + sn * d[2]) >>> FRAC);
          r[1] = p[1];
          r[2] = c[2] + ((cs * d[2] - sn * d[0]) >>> FRAC);
        end
        sat = 1'b0;
        res.x = clamp_coord(r[0], sat);
        res.y = clamp_coord(r[1], sat);
        res.z = clamp_coord(r[2], sat);
        res.sat = sat;
        pending_points.push_back(res);
      end
      default: ; // unused op code leaves everything alone
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // monitors and checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input longint want, input longint got);
    if (fail_count < 100)
      $display("mismatch at %0t: %s expected %0d got %0d", $realtime, what, want, got);
    fail_count++;
  endtask

  // every accepted point transaction feeds the predictor
  always @(posedge clk_i) begin
    if (rst_ni && pts_if.valid && pts_if.ready)
      track_point(pts_if.op, pts_if.x_coord, pts_if.y_coord, pts_if.z_coord);
  end

  // every accepted result transaction is held against the oldest prediction
  always @(posedge clk_i) begin : result_check
    rotated_point_t want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (pending_points.size() == 0) begin
        report_mismatch("result with nothing pending, x_out", 0, res_if.x_out);
      end else begin
        want = pending_points.pop_front();
        if (res_if.x_out !== want.x) report_mismatch("x_out", want.x, res_if.x_out);
        if (res_if.y_out !== want.y) report_mismatch("y_out", want.y, res_if.y_out);
        if (res_if.z_out !== want.z) report_mismatch("z_out", want.z, res_if.z_out);
        if (res_if.saturated !== want.sat)
          report_mismatch("saturated", want.sat, res_if.saturated);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result side: random stalls per transaction, or a long hold-off on request
  // ---------------------------------------------------------------------------

  initial begin : result_sink
    int stall;
    res_if.ready <= 1'b0;
    @(posedge clk_i);
    forever begin
      if (hold_off_cycles != 0) begin
        res_if.ready <= 1'b0;
        repeat (hold_off_cycles) @(posedge clk_i);
        hold_off_cycles = 0;
      end else begin
        stall = rx_idle_on ? $urandom_range(0, 14) : 0;
        if (stall != 0) begin
          res_if.ready <= 1'b0;
          repeat (stall) @(posedge clk_i);
        end
        res_if.ready <= 1'b1;
        // leave early when a hold-off is asked for
        do @(posedge clk_i); while (!(res_if.valid && rst_ni) && hold_off_cycles == 0);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // point side helpers
  // ---------------------------------------------------------------------------

  // one point transaction, preceded by a random gap while tx_idle_on is set
  task automatic send_point(input logic [OP_W-1:0] op,
                            input logic signed [FIELD_W-1:0] x,
                            input logic signed [FIELD_W-1:0] y,
                            input logic signed [FIELD_W-1:0] z);
    int gap;
    gap = tx_idle_on ? $urandom_range(0, 14) : 0;
    if (gap != 0) begin
      pts_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    pts_if.valid   <= 1'b1;
    pts_if.op      <= op;
    pts_if.x_coord <= x;
    pts_if.y_coord <= y;
    pts_if.z_coord <= z;
    do @(posedge clk_i); while (!pts_if.ready);
    items_sent++;
  endtask

  // sender goes quiet until every prediction is matched, then lets the pipe settle
  task automatic wait_for_pending_results();
    int guard;
    guard = 0;
    pts_if.valid <= 1'b0;
    // the last accepted point is predicted at this same edge
    @(posedge clk_i);
    while (pending_points.size() != 0 && guard < 5000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (PIPE_LATENCY + 2) @(posedge clk_i);
  endtask

  // register writes back to back; only called with the block idle
  task automatic set_rotation(input logic axis, input logic signed [TRIG_W-1:0] cs,
                              input logic signed [TRIG_W-1:0] sn);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_AXIS;
    cfg_data_i <= {15'($urandom), axis}; // upper bits are don't-care for the axis
    axis_q = axis;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_COS;
    cfg_data_i <= cs;
    cos_q = cs;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_SIN;
    cfg_data_i <= sn;
    sin_q = sn;
    @(posedge clk_i);
    // the spare index must not disturb anything
    cfg_idx_i  <= CFG_UNUSED;
    cfg_data_i <= 16'($urandom);
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  function automatic logic signed [FIELD_W-1:0] pick_coord();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) begin
      sel = $urandom_range(0, 3);
      if (sel == 0) return COORD_MAX;
      if (sel == 1) return COORD_MIN;
      if (sel == 2) return '0;
      return '1;
    end
    if (sel <= 2) return $urandom;
    return int'($urandom_range(0, 2 * SPREAD)) - SPREAD;
  endfunction

  function automatic logic signed [TRIG_W-1:0] pick_trig();
    return TRIG_W'(int'($urandom_range(0, 32768)) - 16384);
  endfunction

  task automatic send_noise();
    send_point(OP_W'($urandom_range(0, 3)), pick_coord(), pick_coord(), pick_coord());
  endtask

  // measure a cloud, then transform it; stray transactions sneak in now and then
  task automatic run_point_cloud(input int n_points, input bit pause_midway);
    logic signed [FIELD_W-1:0] px [16];
    logic signed [FIELD_W-1:0] py [16];
    logic signed [FIELD_W-1:0] pz [16];
    int i;
    tx_idle_on = ($urandom_range(0, 3) != 0);
    rx_idle_on = ($urandom_range(0, 3) != 0);
    // sometimes the previous box is kept on purpose
    if ($urandom_range(0, 7) != 0)
      send_point(OP_CLEAR, $urandom, $urandom, $urandom);
    for (i = 0; i < n_points; i++) begin
      px[i] = pick_coord();
      py[i] = pick_coord();
      pz[i] = pick_coord();
      send_point(OP_MEASURE, px[i], py[i], pz[i]);
      if ($urandom_range(0, 19) == 0) send_noise();
    end
    for (i = 0; i < n_points; i++) begin
      if (pause_midway && i == n_points / 2) wait_for_pending_results();
      if ($urandom_range(0, 9) == 0)
        send_point(OP_TRANSFORM, pick_coord(), pick_coord(), pick_coord());
      else
        send_point(OP_TRANSFORM, px[i], py[i], pz[i]);
      if ($urandom_range(0, 19) == 0) send_noise();
    end
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // corner points, every op code, seed centre, clear and the saturation paths
  task automatic test_directed_cases();
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    // reset settings are the identity about x; seed centre is zero
    send_point(OP_TRANSFORM, ONE_Q16, 2 * ONE_Q16, -3 * ONE_Q16);
    send_point(OP_UNUSED, COORD_MAX, COORD_MIN, $urandom);
    send_point(OP_MEASURE, COORD_MAX, COORD_MAX, COORD_MAX);
    send_point(OP_MEASURE, COORD_MIN, COORD_MIN, COORD_MIN);
    send_point(OP_TRANSFORM, COORD_MAX, COORD_MIN, 0);
    send_point(OP_TRANSFORM, COORD_MIN, COORD_MAX, -1);
    // clear brings the seeds back
    send_point(OP_CLEAR, 0, 0, 0);
    send_point(OP_TRANSFORM, ONE_Q16, -ONE_Q16, 7);
    wait_for_pending_results();

    // about y with both terms at full scale: sums overflow and clamp
    set_rotation(AXIS_Y, 16'sd16384, 16'sd16384);
    send_point(OP_MEASURE, COORD_MIN, 0, COORD_MIN);
    send_point(OP_MEASURE, COORD_MAX, 0, COORD_MAX);
    send_point(OP_TRANSFORM, COORD_MAX, 5, COORD_MAX);
    send_point(OP_TRANSFORM, COORD_MIN, -5, COORD_MAX);
    send_point(OP_TRANSFORM, COORD_MIN, 0, COORD_MIN);
    wait_for_pending_results();

    // trig values outside the unit circle are taken as they are
    set_rotation(AXIS_X, 16'sh8000, 16'sh7fff);
    send_point(OP_TRANSFORM, 0, COORD_MAX, COORD_MIN);
    send_point(OP_TRANSFORM, 3, 32'sh4000_0000, 32'sh4000_0000);
    send_point(OP_TRANSFORM, COORD_MIN, -1, 1);
    wait_for_pending_results();

    // quarter turn backwards about x
    set_rotation(AXIS_X, 16'sd0, -16'sd16384);
    send_point(OP_CLEAR, 0, 0, 0);
    send_point(OP_MEASURE, ONE_Q16, ONE_Q16, ONE_Q16);
    send_point(OP_TRANSFORM, ONE_Q16, 3 * ONE_Q16, -ONE_Q16);
    wait_for_pending_results();
  endtask

  // well-formed clouds under a sweep of rotation settings, extremes included
  task automatic test_rotation_sweep();
    logic                     axes [8];
    logic signed [TRIG_W-1:0] coss [8];
    logic signed [TRIG_W-1:0] sins [8];
    int ph;
    int start;
    axes[0] = AXIS_X; coss[0] = 16'sd16384;  sins[0] = 16'sd0;
    axes[1] = AXIS_X; coss[1] = 16'sd0;      sins[1] = 16'sd16384;
    axes[2] = AXIS_Y; coss[2] = -16'sd16384; sins[2] = 16'sd0;
    axes[3] = AXIS_Y; coss[3] = 16'sd11585;  sins[3] = 16'sd11585;
    axes[4] = AXIS_X; coss[4] = -16'sd16384; sins[4] = -16'sd16384;
    axes[5] = AXIS_Y; coss[5] = pick_trig(); sins[5] = pick_trig();
    axes[6] = AXIS_X; coss[6] = 16'sh8000;   sins[6] = 16'sh7fff;
    axes[7] = AXIS_Y; coss[7] = 16'sh7fff;   sins[7] = 16'sh8000;
    for (ph = 0; ph < 8; ph++) begin
      set_rotation(axes[ph], coss[ph], sins[ph]);
      start = items_sent;
      while (items_sent - start < 125)
        run_point_cloud($urandom_range(1, 12), 1'b0);
      wait_for_pending_results();
    end
  endtask

  // result side holds off for a long stretch while points keep coming
  task automatic test_output_backpressure();
    int i;
    set_rotation(AXIS_Y, pick_trig(), pick_trig());
    run_point_cloud(16, 1'b0);
    // gapless transforms during the hold-off fill the pipe and stall the input
    tx_idle_on = 1'b0;
    send_point(OP_CLEAR, 0, 0, 0);
    for (i = 0; i < 8; i++)
      send_point(OP_MEASURE, pick_coord(), pick_coord(), pick_coord());
    hold_off_cycles = 200;
    for (i = 0; i < 32; i++)
      send_point(OP_TRANSFORM, pick_coord(), pick_coord(), pick_coord());
    wait_for_pending_results();
  endtask

  // sender stops halfway through a cloud until every result is back
  task automatic test_sender_pause();
    int k;
    set_rotation(AXIS_X, pick_trig(), pick_trig());
    for (k = 0; k < 4; k++)
      run_point_cloud($urandom_range(4, 16), 1'b1);
    wait_for_pending_results();
  endtask

  initial begin
    rst_ni         <= 1'b0;
    cfg_we_i       <= 1'b0;
    cfg_idx_i      <= CFG_AXIS;
    cfg_data_i     <= '0;
    pts_if.valid   <= 1'b0;
    pts_if.op      <= OP_CLEAR;
    pts_if.x_coord <= '0;
    pts_if.y_coord <= '0;
    pts_if.z_coord <= '0;
    axis_q = AXIS_X;
    cos_q  = COS_RESET;
    sin_q  = SIN_RESET;
    reseed_box();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_cases();
    test_rotation_sweep();
    test_output_backpressure();
    test_sender_pause();

    wait_for_pending_results();
    if (pending_points.size() != 0)
      report_mismatch("results never delivered, count", 0, pending_points.size());
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin : watchdog
    #4000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
